>>> hw/rtl/assert_macros.svh
// assertion helpers used by path_normalizer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while in reset
`define PN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must hold even during reset
`define PN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/pn_pkg.sv
// ----------------------------------------------------------------------------
// pn_pkg
// Types and fixed constants of the path normalizer.
// ----------------------------------------------------------------------------
package pn_pkg;

	localparam int OUT_W        = 64;
	localparam int CNT_W        = 4;
	localparam int CMD_W        = 2;
	localparam int OUT_LIMIT_W  = 9;
	localparam int RESULT_CAP   = 32;

	localparam logic [OUT_LIMIT_W-1:0] OUT_LIMIT_RESET = 9'd256;

	localparam logic [7:0] SLASH = 8'h2F;
	localparam logic [7:0] DOT   = 8'h2E;

	localparam logic [CMD_W-1:0] CMD_DIR    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PATH   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NEXT,
		S_DATA,
		S_FLUSH,
		S_ERR
	} state_t;

endpackage

>>> hw/rtl/path_normalizer.sv
// Input: a directory or path character is stored as it is accepted; finish starts the walk in the cycle after.
// Throughput: one input transaction per cycle while characters stream in.
// Finish: each emitted character takes a read step and an append step, each separator one append step,
// then the close (last step, end check, flush); output stalls add to this and no input is taken meanwhile.
// Reset: arst_n clears stack, text state and output valid; out_limit returns to 256.
// The character memory needs no clearing pass: only written entries are ever read.
// ----------------------------------------------------------------------------
// path_normalizer
// Streaming unix path canonicalizer: components are stored in a character
// memory as they arrive and walked on finish into packed result words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module path_normalizer #(
	parameter int MAX_PATH         = 256,
	parameter int MAX_COMPONENTS   = 32,
	parameter int COMPONENT_LEN    = 64,
	parameter int BYTES_PER_RESULT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pn_pkg::OUT_LIMIT_W-1:0]     cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pn_pkg::CMD_W-1:0]           command,
	input  logic [7:0]                         ch,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pn_pkg::OUT_W-1:0]           out_bytes,
	output logic [pn_pkg::CNT_W-1:0]           byte_count,
	output logic                               last,
	output logic                               status
);
	import pn_pkg::*;

	localparam int RW      = $clog2(MAX_COMPONENTS);
	localparam int CW      = $clog2(COMPONENT_LEN);
	localparam int SCW     = $clog2(MAX_COMPONENTS + 1);
	localparam int JLW     = $clog2(MAX_PATH);
	localparam int DEPTH   = 2 ** (RW + CW);
	localparam int OUT_CAP = RESULT_CAP * BYTES_PER_RESULT;

	localparam logic [JLW-1:0]         JL_MAX  = JLW'(MAX_PATH - 1);
	localparam logic [CW-1:0]          CUR_MAX = CW'(COMPONENT_LEN - 1);
	localparam logic [SCW-1:0]         SC_MAX  = SCW'(MAX_COMPONENTS);
	localparam logic [CNT_W-1:0]       BPR     = CNT_W'(BYTES_PER_RESULT);
	localparam logic [OUT_LIMIT_W-1:0] CAP     = OUT_LIMIT_W'(OUT_CAP);

	// control registers
	state_t                 state_q, state_d;
	logic [SCW-1:0]         sc_q, sc_d;
	logic [CW-1:0]          cur_q, cur_d;
	logic [JLW-1:0]         jl_q, jl_d;
	logic                   ps_q, ps_d;
	logic                   pws_q, pws_d;
	logic                   ov_q, ov_d;
	logic [OUT_LIMIT_W-1:0] out_limit_q;

	// payload registers
	logic [7:0]             c0_q, c0_d, c1_q, c1_d;
	logic [SCW-1:0]         k_q, k_d;
	logic [CW-1:0]          j_q, j_d;
	logic [OUT_LIMIT_W-1:0] pos_q, pos_d, lim_q, lim_d;
	logic [OUT_W-1:0]       pack_q, pack_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [OUT_W-1:0]       ob_q, ob_d;
	logic [CNT_W-1:0]       bc_q, bc_d;
	logic                   last_q, last_d, st_q, st_d;

	// memories
	logic [7:0]             mem [DEPTH];
	logic [CW-1:0]          lens_q [MAX_COMPONENTS];
	logic                   wr_en, rd_en, len_we;
	logic [RW+CW-1:0]       wr_addr, rd_addr;
	logic [7:0]             rd_data_q;
	logic [RW-1:0]          len_wa;
	logic [CW-1:0]          len_wd;
	logic [CW-1:0]          clen;
	logic                   out_free;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = ov_q;
	assign out_bytes  = ob_q;
	assign byte_count = bc_q;
	assign last       = last_q;
	assign status     = st_q;
	assign out_free   = !ov_q || out_ready;
	assign clen       = lens_q[k_q[RW-1:0]];

	// next state, text parsing and stack walk
	always_comb begin
		logic                   do_take, do_close, tk_char, app, emit_ok;
		logic [7:0]             ab;
		logic [CW-1:0]          len;
		logic [OUT_LIMIT_W-1:0] lim;
		do_take  = 1'b0;
		do_close = 1'b0;
		tk_char  = 1'b0;
		app      = 1'b0;
		ab       = SLASH;
		len      = '0;
		lim      = '0;
		emit_ok  = 1'b0;
		state_d  = state_q;
		sc_d     = sc_q;
		cur_d    = cur_q;
		jl_d     = jl_q;
		ps_d     = ps_q;
		pws_d    = pws_q;
		c0_d     = c0_q;
		c1_d     = c1_q;
		k_d      = k_q;
		j_d      = j_q;
		pos_d    = pos_q;
		lim_d    = lim_q;
		pack_d   = pack_q;
		cnt_d    = cnt_q;
		ov_d     = ov_q && !out_ready;
		ob_d     = ob_q;
		bc_d     = bc_q;
		last_d   = last_q;
		st_d     = st_q;
		wr_en    = 1'b0;
		wr_addr  = '0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		len_we   = 1'b0;
		len_wa   = '0;
		len_wd   = '0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (command)
						CMD_DIR: begin
							if (ch != '0 && !ps_q) do_take = 1'b1;
						end
						CMD_PATH: begin
							if (ch != '0) begin
								if (!ps_q) begin
									ps_d = 1'b1;
									if (ch == SLASH) begin
										sc_d  = '0;
										cur_d = '0;
										jl_d  = '0;
										pws_d = 1'b0;
									end else if (jl_q != '0 && !pws_q) begin
										// insert the separator between directory and path
										if (jl_d < JL_MAX) begin
											jl_d     = jl_d + JLW'(1);
											pws_d    = 1'b1;
											do_close = 1'b1;
										end
									end
								end
								do_take = 1'b1;
							end
						end
						CMD_FINISH: begin
							do_close = 1'b1;
							lim = (out_limit_q >= OUT_LIMIT_W'(2)) ?
								out_limit_q - OUT_LIMIT_W'(2) : '0;
							lim_d   = (lim > CAP) ? CAP : lim;
							pack_d  = {{(OUT_W-8){1'b0}}, SLASH};
							cnt_d   = CNT_W'(1);
							pos_d   = OUT_LIMIT_W'(1);
							k_d     = '0;
							j_d     = '0;
							state_d = ps_q ? S_NEXT : S_ERR;
						end
						default: ;
					endcase
				end
				// take one character of the joined text
				if (do_take && jl_d < JL_MAX) begin
					jl_d  = jl_d + JLW'(1);
					pws_d = (ch == SLASH);
					if (ch == SLASH) do_close = 1'b1;
					else tk_char = 1'b1;
				end
				// close the current component
				if (do_close) begin
					len   = cur_d;
					cur_d = '0;
					if (len == '0 || (len == CW'(1) && c0_d == DOT)) begin
					end else if (len == CW'(2) && c0_d == DOT && c1_d == DOT) begin
						if (sc_d != '0) sc_d = sc_d - SCW'(1);
					end else if (sc_d < SC_MAX) begin
						len_we = 1'b1;
						len_wa = sc_d[RW-1:0];
						len_wd = len;
						sc_d   = sc_d + SCW'(1);
					end
				end
				// store the character straight into the stack row
				if (tk_char && cur_d < CUR_MAX) begin
					if (sc_d < SC_MAX) begin
						wr_en   = 1'b1;
						wr_addr = {sc_d[RW-1:0], cur_d};
					end
					if (cur_d == '0) c0_d = ch;
					if (cur_d == CW'(1)) c1_d = ch;
					cur_d = cur_d + CW'(1);
				end
			end
			S_NEXT: begin
				if (k_q == sc_q || pos_q >= lim_q) begin
					state_d = S_FLUSH;
				end else if (j_q < clen) begin
					rd_en   = 1'b1;
					rd_addr = {k_q[RW-1:0], j_q};
					state_d = S_DATA;
				end else if (k_q + SCW'(1) < sc_q) begin
					if (cnt_q != BPR || out_free) begin
						app   = 1'b1;
						ab    = SLASH;
						pos_d = pos_q + OUT_LIMIT_W'(1);
						k_d   = k_q + SCW'(1);
						j_d   = '0;
					end
				end else begin
					k_d = k_q + SCW'(1);
				end
			end
			S_DATA: begin
				if (cnt_q != BPR || out_free) begin
					app     = 1'b1;
					ab      = rd_data_q;
					pos_d   = pos_q + OUT_LIMIT_W'(1);
					j_d     = j_q + CW'(1);
					state_d = S_NEXT;
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					ov_d    = 1'b1;
					ob_d    = pack_q;
					bc_d    = cnt_q;
					last_d  = 1'b1;
					st_d    = 1'b0;
					emit_ok = 1'b1;
				end
			end
			S_ERR: begin
				if (out_free) begin
					ov_d    = 1'b1;
					ob_d    = '0;
					bc_d    = '0;
					last_d  = 1'b1;
					st_d    = 1'b1;
					emit_ok = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// end of path: clear text state
		if (emit_ok) begin
			sc_d    = '0;
			cur_d   = '0;
			jl_d    = '0;
			ps_d    = 1'b0;
			pws_d   = 1'b0;
			state_d = S_IDLE;
		end

		// pack one byte, pushing out a full word first
		if (app) begin
			if (cnt_q == BPR) begin
				ov_d   = 1'b1;
				ob_d   = pack_q;
				bc_d   = cnt_q;
				last_d = 1'b0;
				st_d   = 1'b0;
				pack_d = {{(OUT_W-8){1'b0}}, ab};
				cnt_d  = CNT_W'(1);
			end else begin
				pack_d[{cnt_q[2:0], 3'b000} +: 8] = ab;
				cnt_d = cnt_q + CNT_W'(1);
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sc_q        <= '0;
			cur_q       <= '0;
			jl_q        <= '0;
			ps_q        <= 1'b0;
			pws_q       <= 1'b0;
			ov_q        <= 1'b0;
			out_limit_q <= OUT_LIMIT_RESET;
		end else begin
			state_q <= state_d;
			sc_q    <= sc_d;
			cur_q   <= cur_d;
			jl_q    <= jl_d;
			ps_q    <= ps_d;
			pws_q   <= pws_d;
			ov_q    <= ov_d;
			if (cfg_we) out_limit_q <= cfg_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		c0_q   <= c0_d;
		c1_q   <= c1_d;
		k_q    <= k_d;
		j_q    <= j_d;
		pos_q  <= pos_d;
		lim_q  <= lim_d;
		pack_q <= pack_d;
		cnt_q  <= cnt_d;
		ob_q   <= ob_d;
		bc_q   <= bc_d;
		last_q <= last_d;
		st_q   <= st_d;
	end

	// character memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= ch;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// component lengths
	always_ff @(posedge clk) begin
		if (len_we) lens_q[len_wa] <= len_wd;
	end

	`PN_ASSERT(a_err_shape, clk, arst_n, (ov_q && st_q) |-> (bc_q == '0 && last_q), "error result malformed")
	`PN_ASSERT(a_ok_count, clk, arst_n, (ov_q && !st_q) |-> (bc_q != '0 && bc_q <= BPR), "bad byte count")
	`PN_ASSERT(a_stack_bound, clk, arst_n, sc_q <= SC_MAX, "stack count overflow")
	`PN_ASSERT(a_read_data, clk, arst_n, (state_q == S_NEXT && rd_en) |=> (state_q == S_DATA), "read without data state")

endmodule

>>> tb/path_normalizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_normalizer_checker
// Watches the config port and both channels of the path normalizer, keeps
// its own copy of the component stack and text state, predicts the packed
// result words of each finish and compares them field by field.
// ----------------------------------------------------------------------------
module path_normalizer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pn_pkg::OUT_LIMIT_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [pn_pkg::CMD_W-1:0]       command,
	input  logic [7:0]                     ch,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [pn_pkg::OUT_W-1:0]       out_bytes,
	input  logic [pn_pkg::CNT_W-1:0]       byte_count,
	input  logic                           last,
	input  logic                           status,
	output int                             fail_count,
	output int                             pending
);
	import pn_pkg::*;

	localparam int JOIN_MAX  = 255;
	localparam int NAME_MAX  = 63;
	localparam int DEPTH_MAX = 32;
	localparam int TEXT_CAP  = 256;

	typedef struct packed {
		logic [OUT_W-1:0] bytes;
		logic [CNT_W-1:0] cnt;
		logic             fin;
		logic             err;
	} word_t;

	word_t expected_words[$];

	logic [7:0] name_chars [DEPTH_MAX][64];
	int         name_len   [DEPTH_MAX];
	int         depth;
	logic [7:0] cur_chars  [64];
	int         cur_len;
	int         joined_len;
	logic       path_open;
	logic       prev_slash;
	int         out_limit;

	// clears everything a finish or a reset throws away
	task automatic clear_text();
		depth      = 0;
		cur_len    = 0;
		joined_len = 0;
		path_open  = 1'b0;
		prev_slash = 1'b0;
	endtask

	// a slash or a finish closes the current component
	task automatic end_name();
		int n;
		n = cur_len;
		cur_len = 0;
		if (n == 0 || (n == 1 && cur_chars[0] == DOT))
			return;
		if (n == 2 && cur_chars[0] == DOT && cur_chars[1] == DOT) begin
			if (depth > 0)
				depth--;
			return;
		end
		if (depth < DEPTH_MAX) begin
			for (int j = 0; j < n; j++)
				name_chars[depth][j] = cur_chars[j];
			name_len[depth] = n;
			depth++;
		end
	endtask

	task automatic add_char(input logic [7:0] c);
		if (joined_len >= JOIN_MAX)
			return;
		joined_len++;
		prev_slash = (c == SLASH);
		if (c == SLASH)
			end_name();
		else if (cur_len < NAME_MAX) begin
			cur_chars[cur_len] = c;
			cur_len++;
		end
	endtask

	// walk the stack into the canonical text and pack it into words
	task automatic emit_path();
		logic [7:0] text [TEXT_CAP];
		int         lim;
		int         pos;
		int         cnt;
		word_t      w;
		lim = (out_limit >= 2) ? out_limit - 2 : 0;
		if (lim > TEXT_CAP)
			lim = TEXT_CAP;
		pos = 1;
		text[0] = SLASH;
		for (int k = 0; k < depth; k++) begin
			for (int j = 0; j < name_len[k]; j++)
				if (pos < lim) begin
					text[pos] = name_chars[k][j];
					pos++;
				end
			if (k + 1 < depth && pos < lim) begin
				text[pos] = SLASH;
				pos++;
			end
		end
		for (int base = 0; base < pos; base += 8) begin
			cnt = (pos - base > 8) ? 8 : pos - base;
			w = '0;
			for (int j = 0; j < cnt; j++)
				w.bytes[8*j +: 8] = text[base + j];
			w.cnt = CNT_W'(cnt);
			w.fin = (base + 8 >= pos);
			w.err = 1'b0;
			expected_words.push_back(w);
		end
	endtask

	task automatic apply_transaction(input logic [CMD_W-1:0] cmd, input logic [7:0] c);
		word_t w;
		if (cmd == CMD_DIR) begin
			if (c != 0 && !path_open)
				add_char(c);
		end else if (cmd == CMD_PATH) begin
			if (c != 0) begin
				if (!path_open) begin
					path_open = 1'b1;
					if (c == SLASH) begin
						depth      = 0;
						cur_len    = 0;
						joined_len = 0;
						prev_slash = 1'b0;
					end else if (joined_len > 0 && !prev_slash)
						add_char(SLASH);
				end
				add_char(c);
			end
		end else if (cmd == CMD_FINISH) begin
			end_name();
			if (!path_open) begin
				w = '0;
				w.fin = 1'b1;
				w.err = 1'b1;
				expected_words.push_back(w);
			end else
				emit_path();
			clear_text();
		end
	endtask

	task automatic report(input string what, input logic [OUT_W-1:0] got, input logic [OUT_W-1:0] want);
		$display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// compare one result transaction with the oldest prediction
	task automatic check_word();
		word_t w;
		if (expected_words.size() == 0) begin
			report("unexpected result", out_bytes, '0);
			return;
		end
		w = expected_words.pop_front();
		if (out_bytes !== w.bytes)
			report("out_bytes", out_bytes, w.bytes);
		if (byte_count !== w.cnt)
			report("byte_count", OUT_W'(byte_count), OUT_W'(w.cnt));
		if (last !== w.fin)
			report("last", OUT_W'(last), OUT_W'(w.fin));
		if (status !== w.err)
			report("status", OUT_W'(status), OUT_W'(w.err));
	endtask

	initial fail_count = 0;

	// sample all transactions at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit = int'(OUT_LIMIT_RESET);
			clear_text();
			expected_words.delete();
		end else begin
			if (out_valid && out_ready)
				check_word();
			if (cfg_we)
				out_limit = int'(cfg_wdata);
			if (in_valid && in_ready)
				apply_transaction(command, ch);
		end
		pending = expected_words.size();
	end

endmodule

>>> tb/path_normalizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_normalizer_tb
// Drives directory and path characters and finish transactions into the path
// normalizer under several output limits and idle patterns; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module path_normalizer_tb;
	import pn_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = 700;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [OUT_LIMIT_W-1:0] cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic [CMD_W-1:0]       command;
	logic [7:0]             ch;
	logic                   out_valid;
	logic                   out_ready;
	logic [OUT_W-1:0]       out_bytes;
	logic [CNT_W-1:0]       byte_count;
	logic                   last;
	logic                   status;
	int                     fail_count;
	int                     pending;

	int src_idle_pct;
	int snk_idle_pct;
	int items_sent;
	int cycles;
	bit hold_req;
	bit holding;

	path_normalizer uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .ch(ch),
		.out_valid(out_valid), .out_ready(out_ready), .out_bytes(out_bytes),
		.byte_count(byte_count), .last(last), .status(status)
	);

	path_normalizer_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .ch(ch),
		.out_valid(out_valid), .out_ready(out_ready), .out_bytes(out_bytes),
		.byte_count(byte_count), .last(last), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("path_normalizer verification failed");
			$finish;
		end
	end

	// receiver with random stalls, or a long hold-off when asked
	always @(posedge clk)
		out_ready <= !holding && ($urandom_range(0, 99) >= snk_idle_pct);

	initial begin
		holding = 1'b0;
		wait (hold_req);
		holding = 1'b1;
		repeat (400) @(posedge clk);
		holding = 1'b0;
	end

	// one input transaction, with an optional gap before it
	task automatic send(input logic [CMD_W-1:0] cmd, input logic [7:0] c);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		ch       <= c;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_text(input logic [CMD_W-1:0] cmd, input string s);
		for (int i = 0; i < s.len(); i++)
			send(cmd, s[i]);
	endtask

	task automatic run_path(input string dir, input string path);
		send_text(CMD_DIR, dir);
		send_text(CMD_PATH, path);
		send(CMD_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// wait for every predicted word, then for the block to settle
	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_limit(input int v);
		cfg_we    <= 1'b1;
		cfg_wdata <= OUT_LIMIT_W'(v);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic string random_name();
		string s;
		s = "";
		case ($urandom_range(0, 9))
			0: s = ".";
			1, 2: s = "..";
			3: s = "";
			4: repeat ($urandom_range(60, 70)) s = {s, "n"};
			5: repeat ($urandom_range(1, 5)) begin
				byte b;
				b = byte'($urandom_range(1, 255));
				if (b == SLASH)
					b = 8'h80;
				s = {s, string'(b)};
			end
			default: repeat ($urandom_range(1, 4)) begin
				byte b;
				b = byte'($urandom_range(8'h61, 8'h7A));
				s = {s, string'(b)};
			end
		endcase
		return s;
	endfunction

	function automatic string random_tree(input int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = (i == 0) ? random_name() : {s, "/", random_name()};
		return s;
	endfunction

	// mostly well-formed directory and path pairs, some noise
	task automatic random_phase(input int quota);
		string dir;
		string path;
		int    n;
		int    stop_at;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 85) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 4);
				dir = random_tree($urandom_range(0, 3));
				if ($urandom_range(0, 1))
					dir = {"/", dir};
				path = random_tree(n);
				if ($urandom_range(0, 99) < 40)
					path = {"/", path};
				if ($urandom_range(0, 9) == 0)
					path = {path, "/"};
				send_text(CMD_DIR, dir);
				if ($urandom_range(0, 9) == 0)
					send(CMD_RSVD, 8'($urandom_range(0, 255)));
				send_text(CMD_PATH, path);
				if ($urandom_range(0, 9) == 0)
					send(CMD_DIR, 8'($urandom_range(1, 255)));
				if ($urandom_range(0, 9) == 0)
					send(CMD_PATH, 8'h00);
				send(CMD_FINISH, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(0, 8))
					send(CMD_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				send(CMD_FINISH, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		string s;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		command      = '0;
		ch           = '0;
		out_ready    = 1'b0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		items_sent   = 0;
		cycles       = 0;
		hold_req     = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases at the default limit, then at other limits
		set_limit(256);
		send(CMD_FINISH, 8'h00);
		run_path("", "/");
		run_path("/usr/lib", "../x/./y//");
		run_path("", "..");
		run_path("a", "b");
		send(CMD_RSVD, 8'hFF);
		send(CMD_DIR, 8'h00);
		send(CMD_PATH, 8'h00);
		run_path("/d/", "e");
		send(CMD_DIR, 8'h41);
		send(CMD_FINISH, 8'h00);
		s = "";
		repeat (70) s = {s, "x"};
		run_path("", s);
		s = "";
		repeat (34) s = {s, "cd/"};
		run_path("/top", s);
		run_path("", "/\xff\x80/\x7f\x01");
		drain();
		set_limit(3);
		run_path("", "/abc");
		drain();
		set_limit(0);
		run_path("q", "r");
		drain();
		set_limit(511);
		run_path("", "/a/b");
		drain();
		set_limit(10);
		run_path("/home/user", "docs/file.txt");
		drain();

		// random phases with both idle mixes and then none
		set_limit(256);
		src_idle_pct = 23;
		snk_idle_pct = 48;
		random_phase(35);
		drain();
		set_limit(20);
		src_idle_pct = 48;
		snk_idle_pct = 23;
		hold_req = 1'b1;
		random_phase(35);
		drain();
		set_limit(511);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_phase(35);
		drain();

		if (fail_count == 0)
			$display("path_normalizer verification clean");
		else
			$display("path_normalizer verification failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pn_pkg.sv
hw/rtl/path_normalizer.sv
tb/path_normalizer_checker.sv
tb/path_normalizer_tb.sv
